>>> rtl/lnsm_pkg.sv
// Shared types and constants of the letterbox nearest-neighbor scaler map.
// No dependencies; every other file of the block refers to it by scoped names.
package lnsm_pkg;

   localparam int DIM_W  = 13;                   // saturated dimension width
   localparam int POS_W  = 12;                   // view and source coordinate width
   localparam int ADDR_W = 24;                   // linear source address width
   localparam int DQ_W   = POS_W + DIM_W;        // dividend / quotient width of a lane
   localparam int REM_W  = DIM_W - 1;            // remainder stays below the divisor
   localparam int DIV_CELLS = DQ_W;              // one quotient bit per cell
   localparam int SETUP_DQ_W  = 2 * DIM_W;       // dividend of the drawn-size division
   localparam int SETUP_STEPS = SETUP_DQ_W;
   localparam int SETUP_CNT_W = $clog2(SETUP_STEPS);

   localparam logic [DIM_W-1:0] MAX_DIMENSION = DIM_W'(4096);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_WIDTH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_HEIGHT  = 2'd3;

   localparam logic CMD_RENDER  = 1'b0;
   localparam logic CMD_POINTER = 1'b1;

   typedef enum logic [2:0] {
      SETUP_IDLE,
      SETUP_MUL,
      SETUP_SEL,
      SETUP_DIV,
      SETUP_FIN
   } lnsm_setup_state_type;

   // geometry derived from the registers; new items wait while it is recomputed
   typedef struct packed {
      logic             busy;
      logic             nonzero;
      logic [DIM_W-1:0] fw;
      logic [DIM_W-1:0] fh;
      logic [DIM_W-1:0] num;
      logic [DIM_W-1:0] den;
      logic [DIM_W-1:0] dw;
      logic [DIM_W-1:0] dh;
      logic [DIM_W-1:0] left;
      logic [DIM_W-1:0] top;
   } lnsm_geom_type;

   typedef struct packed {
      logic cmd;
      logic inx;
      logic iny;
   } lnsm_flags_type;

   typedef struct packed {
      lnsm_flags_type   flags;
      logic [POS_W-1:0] dx;
      logic [POS_W-1:0] dy;
   } lnsm_front_type;

   // dq shifts dividend bits out at the top and quotient bits in at the bottom
   typedef struct packed {
      lnsm_flags_type   flags;
      logic [DQ_W-1:0]  dq_x;
      logic [DQ_W-1:0]  dq_y;
      logic [REM_W-1:0] rem_x;
      logic [REM_W-1:0] rem_y;
   } lnsm_div_type;

   typedef struct packed {
      logic             valid_res;
      logic             inside_res;
      logic [POS_W-1:0] sx;
      logic [POS_W-1:0] sy;
   } lnsm_map_type;

endpackage

>>> rtl/lnsm_geometry.sv
// Configuration registers and the setup sequencer that derives scale, drawn size
// and offsets after each write. Depends on lnsm_pkg.
module lnsm_geometry (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lnsm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lnsm_pkg::DIM_W-1:0]     csr_data,
   output lnsm_pkg::lnsm_geom_type        geom
);

   logic [lnsm_pkg::DIM_W-1:0] frame_width_ff, frame_height_ff;
   logic [lnsm_pkg::DIM_W-1:0] view_width_ff, view_height_ff;
   logic [lnsm_pkg::DIM_W-1:0] fw, fh, vw, vh;
   logic                       csr_write;

   lnsm_pkg::lnsm_setup_state_type state_ff, state_in;
   logic [lnsm_pkg::SETUP_DQ_W-1:0]  prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic [lnsm_pkg::SETUP_DQ_W-1:0]  dq_ff, dq_in;
   logic [lnsm_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [lnsm_pkg::SETUP_CNT_W-1:0] count_ff, count_in;
   logic                             sel_w_ff, sel_w_in;
   logic [lnsm_pkg::DIM_W-1:0] num_ff, num_in, den_ff, den_in;
   logic [lnsm_pkg::DIM_W-1:0] dw_ff, dw_in, dh_ff, dh_in;
   logic [lnsm_pkg::DIM_W-1:0] left_ff, left_in, top_ff, top_in;

   logic [lnsm_pkg::REM_W:0]   trial;
   logic                       trial_ge;
   logic [lnsm_pkg::DIM_W-1:0] quot, dw_raw, dh_raw, dw_fin, dh_fin;

   function automatic logic [lnsm_pkg::DIM_W-1:0] sat_dim(
      input logic [lnsm_pkg::DIM_W-1:0] v);
      return (v > lnsm_pkg::MAX_DIMENSION) ? lnsm_pkg::MAX_DIMENSION : v;
   endfunction

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
         view_width_ff   <= '0;
         view_height_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            lnsm_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            lnsm_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_data;
            lnsm_pkg::REG_VIEW_WIDTH:   view_width_ff   <= csr_data;
            lnsm_pkg::REG_VIEW_HEIGHT:  view_height_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign fw = sat_dim(frame_width_ff);
   assign fh = sat_dim(frame_height_ff);
   assign vw = sat_dim(view_width_ff);
   assign vh = sat_dim(view_height_ff);

   // one restoring step of the drawn-size division
   assign trial    = {rem_ff, dq_ff[lnsm_pkg::SETUP_DQ_W-1]};
   assign trial_ge = trial >= lnsm_pkg::DIM_W'(den_ff);

   // quotient is at most the view size, so it fits a dimension
   assign quot   = dq_ff[lnsm_pkg::DIM_W-1:0];
   assign dw_raw = sel_w_ff ? vw : quot;
   assign dh_raw = sel_w_ff ? quot : vh;
   assign dw_fin = (dw_raw == '0) ? lnsm_pkg::DIM_W'(1) : dw_raw;
   assign dh_fin = (dh_raw == '0) ? lnsm_pkg::DIM_W'(1) : dh_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lnsm_pkg::SETUP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      dq_ff     <= dq_in;
      rem_ff    <= rem_in;
      count_ff  <= count_in;
      sel_w_ff  <= sel_w_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      dw_ff     <= dw_in;
      dh_ff     <= dh_in;
      left_ff   <= left_in;
      top_ff    <= top_in;
   end

   always_comb begin
      state_in  = state_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      dq_in     = dq_ff;
      rem_in    = rem_ff;
      count_in  = count_ff;
      sel_w_in  = sel_w_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      dw_in     = dw_ff;
      dh_in     = dh_ff;
      left_in   = left_ff;
      top_in    = top_ff;
      case (state_ff)
         lnsm_pkg::SETUP_IDLE: ;
         lnsm_pkg::SETUP_MUL: begin
            prod_a_in = lnsm_pkg::SETUP_DQ_W'(vw) * lnsm_pkg::SETUP_DQ_W'(fh);
            prod_b_in = lnsm_pkg::SETUP_DQ_W'(vh) * lnsm_pkg::SETUP_DQ_W'(fw);
            state_in  = lnsm_pkg::SETUP_SEL;
         end
         lnsm_pkg::SETUP_SEL: begin
            // width ratio wins ties; its drawn width is the view width itself
            sel_w_in = prod_a_ff <= prod_b_ff;
            num_in   = (prod_a_ff <= prod_b_ff) ? vw : vh;
            den_in   = (prod_a_ff <= prod_b_ff) ? fw : fh;
            dq_in    = (prod_a_ff <= prod_b_ff) ? prod_a_ff : prod_b_ff;
            rem_in   = '0;
            count_in = '0;
            state_in = lnsm_pkg::SETUP_DIV;
         end
         lnsm_pkg::SETUP_DIV: begin
            rem_in   = trial_ge ? lnsm_pkg::REM_W'(trial - lnsm_pkg::DIM_W'(den_ff))
                                : trial[lnsm_pkg::REM_W-1:0];
            dq_in    = {dq_ff[lnsm_pkg::SETUP_DQ_W-2:0], trial_ge};
            count_in = count_ff + 1'b1;
            if (count_ff == lnsm_pkg::SETUP_CNT_W'(lnsm_pkg::SETUP_STEPS - 1)) begin
               state_in = lnsm_pkg::SETUP_FIN;
            end
         end
         lnsm_pkg::SETUP_FIN: begin
            dw_in    = dw_fin;
            dh_in    = dh_fin;
            left_in  = (vw > dw_fin) ? ((vw - dw_fin) >> 1) : '0;
            top_in   = (vh > dh_fin) ? ((vh - dh_fin) >> 1) : '0;
            state_in = lnsm_pkg::SETUP_IDLE;
         end
         default: state_in = lnsm_pkg::SETUP_IDLE;
      endcase
      // any write restarts the derivation from the new register set
      if (csr_write) begin
         state_in = lnsm_pkg::SETUP_MUL;
      end
   end

   assign geom.busy    = state_ff != lnsm_pkg::SETUP_IDLE;
   assign geom.nonzero = (fw != '0) && (fh != '0) && (vw != '0) && (vh != '0);
   assign geom.fw      = fw;
   assign geom.fh      = fh;
   assign geom.num     = num_ff;
   assign geom.den     = den_ff;
   assign geom.dw      = dw_ff;
   assign geom.dh      = dh_ff;
   assign geom.left    = left_ff;
   assign geom.top     = top_ff;

endmodule

>>> rtl/lnsm_div_cell.sv
// One cell of the divider chain: a restoring step for the x and y lanes plus
// its own valid bit and elastic handshake. Depends on lnsm_pkg.
module lnsm_div_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lnsm_pkg::DIM_W-1:0] num,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  lnsm_pkg::lnsm_div_type     up_data,
   output logic                       down_valid,
   input  logic                       down_ready,
   output lnsm_pkg::lnsm_div_type     down_data
);

   logic                   valid_ff, valid_in;
   lnsm_pkg::lnsm_div_type data_ff, data_in;
   logic [lnsm_pkg::REM_W:0] trial_x, trial_y;
   logic                     ge_x, ge_y;

   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   assign trial_x = {up_data.rem_x, up_data.dq_x[lnsm_pkg::DQ_W-1]};
   assign trial_y = {up_data.rem_y, up_data.dq_y[lnsm_pkg::DQ_W-1]};
   assign ge_x    = trial_x >= num;
   assign ge_y    = trial_y >= num;

   always_comb begin
      data_in.flags = up_data.flags;
      data_in.dq_x  = {up_data.dq_x[lnsm_pkg::DQ_W-2:0], ge_x};
      data_in.dq_y  = {up_data.dq_y[lnsm_pkg::DQ_W-2:0], ge_y};
      data_in.rem_x = ge_x ? lnsm_pkg::REM_W'(trial_x - num) : trial_x[lnsm_pkg::REM_W-1:0];
      data_in.rem_y = ge_y ? lnsm_pkg::REM_W'(trial_y - num) : trial_y[lnsm_pkg::REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

>>> rtl/letterbox_nearest_scaler_map_core.sv
// A req transfer loads the offset stage; the multiply stage, 25 divider cells, the clamp
// stage and the address stage follow, and rsp_valid comes from the address stage.
// Throughput: one item per cycle while rsp is ready and no geometry setup runs; each
// stage holds an item while rsp stalls, so req is taken until the chain is full.
// A csr write holds req_ready low while the geometry divider runs.
// Reset (synchronous) clears the csr registers and valid bits, idles setup and empties the chain.
module letterbox_nearest_scaler_map_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [lnsm_pkg::POS_W-1:0]     req_view_x,
   input  logic [lnsm_pkg::POS_W-1:0]     req_view_y,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_valid_res,
   output logic                           rsp_inside_res,
   output logic [lnsm_pkg::POS_W-1:0]     rsp_source_x,
   output logic [lnsm_pkg::POS_W-1:0]     rsp_source_y,
   output logic [lnsm_pkg::ADDR_W-1:0]    rsp_source_address,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lnsm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lnsm_pkg::DIM_W-1:0]     csr_data
);

   lnsm_pkg::lnsm_geom_type geom;

   lnsm_geometry u_geometry (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom)
   );

   // ---------------- stage A: offsets and inside test
   logic                     a_valid_ff, a_valid_in, a_ready, a_load;
   lnsm_pkg::lnsm_front_type a_ff, a_in;
   logic                     x_ge, y_ge;

   assign x_ge = lnsm_pkg::DIM_W'(req_view_x) >= geom.left;
   assign y_ge = lnsm_pkg::DIM_W'(req_view_y) >= geom.top;

   always_comb begin
      a_in.flags.cmd = req_command;
      a_in.dx        = x_ge ? lnsm_pkg::POS_W'(lnsm_pkg::DIM_W'(req_view_x) - geom.left) : '0;
      a_in.dy        = y_ge ? lnsm_pkg::POS_W'(lnsm_pkg::DIM_W'(req_view_y) - geom.top) : '0;
      a_in.flags.inx = x_ge && (lnsm_pkg::DIM_W'(a_in.dx) < geom.dw);
      a_in.flags.iny = y_ge && (lnsm_pkg::DIM_W'(a_in.dy) < geom.dh);
   end

   logic b_ready;
   assign req_ready  = a_ready && !geom.busy;
   assign a_load     = req_valid && req_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign a_valid_in = a_ready ? a_load : a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_ff <= a_in;
      end
   end

   // ---------------- stage B: dividends, offset times the scale denominator
   logic                   div_valid [0:lnsm_pkg::DIV_CELLS];
   logic                   div_ready [0:lnsm_pkg::DIV_CELLS];
   lnsm_pkg::lnsm_div_type div_data  [0:lnsm_pkg::DIV_CELLS];

   logic                   b_valid_ff, b_valid_in, b_load;
   lnsm_pkg::lnsm_div_type b_ff, b_in;

   always_comb begin
      b_in.flags = a_ff.flags;
      b_in.dq_x  = lnsm_pkg::DQ_W'(a_ff.dx) * lnsm_pkg::DQ_W'(geom.den);
      b_in.dq_y  = lnsm_pkg::DQ_W'(a_ff.dy) * lnsm_pkg::DQ_W'(geom.den);
      b_in.rem_x = '0;
      b_in.rem_y = '0;
   end

   assign b_ready    = !b_valid_ff || div_ready[0];
   assign b_load     = a_valid_ff && b_ready;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_ff <= b_in;
      end
   end

   assign div_valid[0] = b_valid_ff;
   assign div_data[0]  = b_ff;

   // ---------------- divider chain, one quotient bit per cell
   for (genvar k = 0; k < lnsm_pkg::DIV_CELLS; k++) begin : g_cell
      lnsm_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .num        (geom.num),
         .up_valid   (div_valid[k]),
         .up_ready   (div_ready[k]),
         .up_data    (div_data[k]),
         .down_valid (div_valid[k+1]),
         .down_ready (div_ready[k+1]),
         .down_data  (div_data[k+1])
      );
   end

   // ---------------- stage C: clamp into the frame, blank outside render results
   logic                   c_valid_ff, c_valid_in, c_ready, c_load;
   lnsm_pkg::lnsm_map_type c_ff, c_in;
   lnsm_pkg::lnsm_div_type q;
   logic [lnsm_pkg::DIM_W-1:0] fw_m1, fh_m1;
   logic [lnsm_pkg::POS_W-1:0] sx_clamp, sy_clamp;
   logic                       show;

   assign q        = div_data[lnsm_pkg::DIV_CELLS];
   assign fw_m1    = geom.fw - 1'b1;
   assign fh_m1    = geom.fh - 1'b1;
   assign sx_clamp = (q.dq_x > lnsm_pkg::DQ_W'(fw_m1)) ? fw_m1[lnsm_pkg::POS_W-1:0]
                                                        : q.dq_x[lnsm_pkg::POS_W-1:0];
   assign sy_clamp = (q.dq_y > lnsm_pkg::DQ_W'(fh_m1)) ? fh_m1[lnsm_pkg::POS_W-1:0]
                                                        : q.dq_y[lnsm_pkg::POS_W-1:0];
   assign show     = geom.nonzero &&
                     ((q.flags.cmd == lnsm_pkg::CMD_POINTER) || (q.flags.inx && q.flags.iny));

   always_comb begin
      c_in.valid_res  = geom.nonzero;
      c_in.inside_res = show;
      c_in.sx         = show ? sx_clamp : '0;
      c_in.sy         = show ? sy_clamp : '0;
   end

   logic d_ready;
   assign div_ready[lnsm_pkg::DIV_CELLS] = c_ready;
   assign c_ready    = !c_valid_ff || d_ready;
   assign c_load     = div_valid[lnsm_pkg::DIV_CELLS] && c_ready;
   assign c_valid_in = c_ready ? div_valid[lnsm_pkg::DIV_CELLS] : c_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         c_ff <= c_in;
      end
   end

   // ---------------- stage D: linear address, output register
   logic                        d_valid_ff, d_valid_in, d_load;
   lnsm_pkg::lnsm_map_type      d_ff;
   logic [lnsm_pkg::ADDR_W-1:0] addr_ff, addr_in;

   // blanked results carry zero coordinates, so the address comes out zero
   assign addr_in = lnsm_pkg::ADDR_W'(
                       lnsm_pkg::DQ_W'(c_ff.sy) * lnsm_pkg::DQ_W'(geom.fw)
                     + lnsm_pkg::DQ_W'(c_ff.sx));

   assign d_ready    = !d_valid_ff || rsp_ready;
   assign d_load     = c_valid_ff && d_ready;
   assign d_valid_in = d_ready ? c_valid_ff : d_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (d_load) begin
         d_ff    <= c_ff;
         addr_ff <= addr_in;
      end
   end

   assign rsp_valid          = d_valid_ff;
   assign rsp_valid_res      = d_ff.valid_res;
   assign rsp_inside_res     = d_ff.inside_res;
   assign rsp_source_x       = d_ff.sx;
   assign rsp_source_y       = d_ff.sy;
   assign rsp_source_address = addr_ff;

endmodule

>>> rtl/lnsm_checker.sv
// Port-level checks of the scaler map core, attached by the bind below.
// Depends on lnsm_pkg and letterbox_nearest_scaler_map_core.
module lnsm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_command,
   input logic [lnsm_pkg::POS_W-1:0]     req_view_x,
   input logic [lnsm_pkg::POS_W-1:0]     req_view_y,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_valid_res,
   input logic                           rsp_inside_res,
   input logic [lnsm_pkg::POS_W-1:0]     rsp_source_x,
   input logic [lnsm_pkg::POS_W-1:0]     rsp_source_y,
   input logic [lnsm_pkg::ADDR_W-1:0]    rsp_source_address,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [lnsm_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [lnsm_pkg::DIM_W-1:0]     csr_data
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_source_address) && $stable(rsp_source_x))
      else $error("rsp payload changed while stalled");

   // no geometry means an all-zero result
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
         !rsp_inside_res && rsp_source_x == '0 && rsp_source_y == '0 &&
         rsp_source_address == '0)
      else $error("invalid geometry gave nonzero result");

   // a blanked pixel carries no source
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |->
         rsp_source_x == '0 && rsp_source_y == '0 && rsp_source_address == '0)
      else $error("outside pixel gave a source");

   // the geometry is being recomputed after a register transfer
   a_setup_block: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("req taken during geometry setup");

endmodule

bind letterbox_nearest_scaler_map_core lnsm_checker u_lnsm_checker (.*);
